// ===== design/ndl_pkg.sv =====
// ----------------------------------------------------------------------------
// ndl_pkg
// Shared widths, reset values, register indexes and types for the
// nearest-neighbor downscaler with luma output.
// ----------------------------------------------------------------------------
package ndl_pkg;

  // Dimension width and the wider error-term width
  localparam int unsigned DimBits  = 12;
  localparam int unsigned ErrBits  = DimBits + 2;
  localparam int unsigned ChanBits = 8;
  localparam int unsigned CfgIdxBits = 2;

  // Luma coefficients (sum of coefficients is 256)
  localparam int unsigned CoefR = 77;
  localparam int unsigned CoefG = 150;
  localparam int unsigned CoefB = 29;
  localparam int unsigned LumaShift = 8;
  localparam int unsigned LumaSumBits = ChanBits + LumaShift;

  // Register reset values
  localparam logic [DimBits-1:0] SrcWidthRst  = DimBits'(320);
  localparam logic [DimBits-1:0] SrcHeightRst = DimBits'(240);
  localparam logic [DimBits-1:0] OutWidthRst  = DimBits'(320);
  localparam logic [DimBits-1:0] OutHeightRst = DimBits'(240);

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CfgSrcWidth  = 2'd0,
    CfgSrcHeight = 2'd1,
    CfgOutWidth  = 2'd2,
    CfgOutHeight = 2'd3
  } cfg_idx_e;

  // Effective frame sizes after zero and upscale clamping
  typedef struct packed {
    logic [DimBits-1:0] src_w;
    logic [DimBits-1:0] src_h;
    logic [DimBits-1:0] out_w;
    logic [DimBits-1:0] out_h;
  } dims_t;

  // Pick decision for the current source pixel
  typedef struct packed {
    logic pick;
    logic row_end;
    logic frame_end;
  } pick_t;

endpackage

// ===== design/ndl_if.sv =====
// ----------------------------------------------------------------------------
// ndl_if
// Valid/ready channel interfaces: source pixel, gray result and
// configuration write.
// ----------------------------------------------------------------------------
interface ndl_pix_if;
  logic                         valid;
  logic                         ready;
  logic [ndl_pkg::ChanBits-1:0] red;
  logic [ndl_pkg::ChanBits-1:0] green;
  logic [ndl_pkg::ChanBits-1:0] blue;
  logic                         frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface ndl_gray_if;
  logic                         valid;
  logic                         ready;
  logic [ndl_pkg::ChanBits-1:0] gray;
  logic                         row_end;
  logic                         frame_end;

  modport source (output valid, gray, row_end, frame_end, input ready);
  modport sink   (input valid, gray, row_end, frame_end, output ready);
endinterface

interface ndl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ndl_pkg::CfgIdxBits-1:0] index;
  logic [ndl_pkg::DimBits-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ndl_cfg.sv =====
// ----------------------------------------------------------------------------
// ndl_cfg
// Size registers with write port; derives effective sizes (zero acts as
// one, output sizes clamped to source sizes).
// ----------------------------------------------------------------------------
module ndl_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  ndl_cfg_if.sink            cfg_i,
  output ndl_pkg::dims_t     dims_o
);

  logic [ndl_pkg::DimBits-1:0] src_w_q, src_h_q, out_w_q, out_h_q;
  logic [ndl_pkg::DimBits-1:0] sw, sh, ow, oh;

  // Always take configuration transfers
  assign cfg_i.ready = 1'b1;

  // Store written registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= ndl_pkg::SrcWidthRst;
      src_h_q <= ndl_pkg::SrcHeightRst;
      out_w_q <= ndl_pkg::OutWidthRst;
      out_h_q <= ndl_pkg::OutHeightRst;
    end else if (cfg_i.valid) begin
      unique case (ndl_pkg::cfg_idx_e'(cfg_i.index))
        ndl_pkg::CfgSrcWidth:  src_w_q <= cfg_i.data;
        ndl_pkg::CfgSrcHeight: src_h_q <= cfg_i.data;
        ndl_pkg::CfgOutWidth:  out_w_q <= cfg_i.data;
        ndl_pkg::CfgOutHeight: out_h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Treat zero as one, then clamp output sizes to source sizes
  always_comb begin
    sw = (src_w_q == '0) ? ndl_pkg::DimBits'(1) : src_w_q;
    sh = (src_h_q == '0) ? ndl_pkg::DimBits'(1) : src_h_q;
    ow = (out_w_q == '0) ? ndl_pkg::DimBits'(1) : out_w_q;
    oh = (out_h_q == '0) ? ndl_pkg::DimBits'(1) : out_h_q;
    if (ow > sw) ow = sw;
    if (oh > sh) oh = sh;
    dims_o.src_w = sw;
    dims_o.src_h = sh;
    dims_o.out_w = ow;
    dims_o.out_h = oh;
  end

endmodule

// ===== design/ndl_track.sv =====
// ----------------------------------------------------------------------------
// ndl_track
// Column and row position counters with error terms; decides whether the
// current source pixel is the nearest one to an output position.
// ----------------------------------------------------------------------------
module ndl_track (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ndl_pkg::dims_t     dims_i,
  input  logic               advance_i,
  input  logic               frame_start_i,
  output ndl_pkg::pick_t     pick_o
);

  localparam int unsigned DB = ndl_pkg::DimBits;
  localparam int unsigned EB = ndl_pkg::ErrBits;

  logic [DB-1:0] src_col_q, src_row_q, out_col_q, out_row_q;
  logic [EB-1:0] col_err_q, row_err_q;
  logic [DB-1:0] src_col_d, src_row_d, out_col_d, out_row_d;
  logic [EB-1:0] col_err_d, row_err_d;

  logic [DB-1:0] sc, sr, oc, orow;
  logic [EB-1:0] ce, re;
  logic [EB-1:0] sw_e, sh_e, ow_e, oh_e;
  logic          col_pick, row_pick, rend;

  always_comb begin
    // Clear position first on a frame start
    sc   = frame_start_i ? '0 : src_col_q;
    sr   = frame_start_i ? '0 : src_row_q;
    oc   = frame_start_i ? '0 : out_col_q;
    orow = frame_start_i ? '0 : out_row_q;
    ce   = frame_start_i ? '0 : col_err_q;
    re   = frame_start_i ? '0 : row_err_q;

    sw_e = EB'(dims_i.src_w);
    sh_e = EB'(dims_i.src_h);
    ow_e = EB'(dims_i.out_w);
    oh_e = EB'(dims_i.out_h);

    // Pick when both axes are still inside the output and on target
    col_pick = (oc < dims_i.out_w) && (ce < ow_e);
    row_pick = (orow < dims_i.out_h) && (re < oh_e);
    rend     = (oc == dims_i.out_w - DB'(1));

    pick_o.pick      = col_pick && row_pick;
    pick_o.row_end   = rend;
    pick_o.frame_end = rend && (orow == dims_i.out_h - DB'(1));

    // Step column state
    src_row_d = sr;
    out_row_d = orow;
    row_err_d = re;
    if (col_pick) begin
      out_col_d = oc + DB'(1);
      col_err_d = ce + sw_e - ow_e;
    end else begin
      out_col_d = oc;
      col_err_d = ce - ow_e;
    end

    // Wrap at source row end, step row state, wrap at frame end
    if (sc >= dims_i.src_w - DB'(1)) begin
      src_col_d = '0;
      out_col_d = '0;
      col_err_d = '0;
      if (row_pick) begin
        out_row_d = orow + DB'(1);
        row_err_d = re + sh_e - oh_e;
      end else begin
        row_err_d = re - oh_e;
      end
      if (sr >= dims_i.src_h - DB'(1)) begin
        src_row_d = '0;
        out_row_d = '0;
        row_err_d = '0;
      end else begin
        src_row_d = sr + DB'(1);
      end
    end else begin
      src_col_d = sc + DB'(1);
    end
  end

  // Update state when a pixel leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      col_err_q <= '0;
      row_err_q <= '0;
    end else if (advance_i) begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      col_err_q <= col_err_d;
      row_err_q <= row_err_d;
    end
  end

endmodule

// ===== design/ndl_luma.sv =====
// ----------------------------------------------------------------------------
// ndl_luma
// BT.601 luma from RGB with constant coefficients: (77R+150G+29B)>>8.
// ----------------------------------------------------------------------------
module ndl_luma (
  input  logic [ndl_pkg::ChanBits-1:0] red_i,
  input  logic [ndl_pkg::ChanBits-1:0] green_i,
  input  logic [ndl_pkg::ChanBits-1:0] blue_i,
  output logic [ndl_pkg::ChanBits-1:0] gray_o
);

  localparam int unsigned SB = ndl_pkg::LumaSumBits;

  logic [SB-1:0] sum;

  // Weighted sum fits the width since the coefficients add to 256
  assign sum = SB'(ndl_pkg::CoefR) * SB'(red_i)
             + SB'(ndl_pkg::CoefG) * SB'(green_i)
             + SB'(ndl_pkg::CoefB) * SB'(blue_i);

  assign gray_o = sum[SB-1:ndl_pkg::LumaShift];

endmodule

// ===== design/nearest_downscale_to_luma.sv =====
// ----------------------------------------------------------------------------
// nearest_downscale_to_luma
// Nearest-neighbor downscaler producing BT.601 luma with row and frame marks.
// A picked pixel passes the input register, then the result register, to gray_o.
// Throughput: one source pixel per cycle while gray_o is not stalled.
// Reset: positions and error terms clear; sizes return to 320x240 in and out.
// ----------------------------------------------------------------------------
module nearest_downscale_to_luma (
  input  logic     clk_i,
  input  logic     rst_ni,
  ndl_cfg_if.sink  cfg_i,
  ndl_pix_if.sink  pix_i,
  ndl_gray_if.source gray_o
);

  localparam int unsigned CB = ndl_pkg::ChanBits;

  ndl_pkg::dims_t dims;
  ndl_pkg::pick_t pick;

  logic          in_vld_q;
  logic [CB-1:0] red_q, green_q, blue_q;
  logic          fs_q;
  logic          advance;

  logic          out_vld_q;
  logic [CB-1:0] gray_q, gray_d;
  logic          rend_q, fend_q;

  // Move the held pixel on when the result register is free or drains
  assign advance     = in_vld_q && (!out_vld_q || gray_o.ready);
  assign pix_i.ready = !in_vld_q || advance;

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (pix_i.ready) begin
      in_vld_q <= pix_i.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      red_q   <= pix_i.red;
      green_q <= pix_i.green;
      blue_q  <= pix_i.blue;
      fs_q    <= pix_i.frame_start;
    end
  end

  ndl_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .dims_o (dims)
  );

  ndl_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dims_i        (dims),
    .advance_i     (advance),
    .frame_start_i (fs_q),
    .pick_o        (pick)
  );

  ndl_luma u_luma (
    .red_i   (red_q),
    .green_i (green_q),
    .blue_i  (blue_q),
    .gray_o  (gray_d)
  );

  // Result register valid: load on a picked pixel, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= pick.pick;
    end else if (gray_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance && pick.pick) begin
      gray_q <= gray_d;
      rend_q <= pick.row_end;
      fend_q <= pick.frame_end;
    end
  end

  assign gray_o.valid     = out_vld_q;
  assign gray_o.gray      = gray_q;
  assign gray_o.row_end   = rend_q;
  assign gray_o.frame_end = fend_q;

endmodule

// ===== sim/nearest_downscale_to_luma_checker.sv =====
// ----------------------------------------------------------------------------
// nearest_downscale_to_luma_checker
// Watches the configuration, pixel and gray channels of the downscaler,
// tracks the register values and the column/row pick state on every pixel
// transfer, and compares each gray transfer field by field with the oldest
// predicted luma result.
// ----------------------------------------------------------------------------
module nearest_downscale_to_luma_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ndl_cfg_if          cfg_i,
  ndl_pix_if          pix_i,
  ndl_gray_if         gray_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Keep the log readable when a broken block fails on every result
  localparam int unsigned MaxPrinted = 100;

  typedef struct packed {
    logic [ndl_pkg::ChanBits-1:0] gray;
    logic                         row_end;
    logic                         frame_end;
  } luma_pick_t;

  // Register copies
  logic [ndl_pkg::DimBits-1:0] src_w_q;
  logic [ndl_pkg::DimBits-1:0] src_h_q;
  logic [ndl_pkg::DimBits-1:0] out_w_q;
  logic [ndl_pkg::DimBits-1:0] out_h_q;

  // Position and error-term state
  logic [ndl_pkg::DimBits-1:0] src_col;
  logic [ndl_pkg::DimBits-1:0] src_row;
  logic [ndl_pkg::DimBits-1:0] out_col;
  logic [ndl_pkg::DimBits-1:0] out_row;
  logic [ndl_pkg::ErrBits-1:0] col_err;
  logic [ndl_pkg::ErrBits-1:0] row_err;

  luma_pick_t luma_due_q[$];

  task automatic report_mismatch(input string msg);
    if (fail_count_o < MaxPrinted) begin
      $display("[%0t] luma check: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  task automatic clear_position();
    src_col = '0;
    src_row = '0;
    out_col = '0;
    out_row = '0;
    col_err = '0;
    row_err = '0;
  endtask

  // Advance the pick state by one source pixel and queue its luma if picked
  task automatic step_downscaler(input logic [ndl_pkg::ChanBits-1:0] r,
                                 input logic [ndl_pkg::ChanBits-1:0] g,
                                 input logic [ndl_pkg::ChanBits-1:0] b, input logic fs);
    logic [ndl_pkg::DimBits-1:0] sw;
    logic [ndl_pkg::DimBits-1:0] sh;
    logic [ndl_pkg::DimBits-1:0] ow;
    logic [ndl_pkg::DimBits-1:0] oh;
    logic [ndl_pkg::ErrBits-1:0] sw_e;
    logic [ndl_pkg::ErrBits-1:0] sh_e;
    logic [ndl_pkg::ErrBits-1:0] ow_e;
    logic [ndl_pkg::ErrBits-1:0] oh_e;
    logic                        col_hit;
    logic                        row_hit;
    int unsigned                 weighted;
    luma_pick_t                  pick;

    if (fs) begin
      clear_position();
    end

    // Zero sizes act as one; output sizes never exceed the source
    sw = (src_w_q == '0) ? ndl_pkg::DimBits'(1) : src_w_q;
    sh = (src_h_q == '0) ? ndl_pkg::DimBits'(1) : src_h_q;
    ow = (out_w_q == '0) ? ndl_pkg::DimBits'(1) : out_w_q;
    oh = (out_h_q == '0) ? ndl_pkg::DimBits'(1) : out_h_q;
    if (ow > sw) begin
      ow = sw;
    end
    if (oh > sh) begin
      oh = sh;
    end
    sw_e = ndl_pkg::ErrBits'(sw);
    sh_e = ndl_pkg::ErrBits'(sh);
    ow_e = ndl_pkg::ErrBits'(ow);
    oh_e = ndl_pkg::ErrBits'(oh);

    col_hit = (out_col < ow) && (col_err < ow_e);
    row_hit = (out_row < oh) && (row_err < oh_e);

    if (col_hit && row_hit) begin
      weighted       = ndl_pkg::CoefR * r + ndl_pkg::CoefG * g + ndl_pkg::CoefB * b;
      pick.gray      = ndl_pkg::ChanBits'(weighted >> ndl_pkg::LumaShift);
      pick.row_end   = (out_col == ow - ndl_pkg::DimBits'(1));
      pick.frame_end = pick.row_end && (out_row == oh - ndl_pkg::DimBits'(1));
      luma_due_q.push_back(pick);
    end

    // Column step; the error term wraps at its own width
    if (col_hit) begin
      out_col = out_col + ndl_pkg::DimBits'(1);
      col_err = col_err + sw_e - ow_e;
    end else begin
      col_err = col_err - ow_e;
    end

    // Source row end: clear column state, step the row, wrap the frame
    if (src_col >= sw - ndl_pkg::DimBits'(1)) begin
      src_col = '0;
      out_col = '0;
      col_err = '0;
      if (row_hit) begin
        out_row = out_row + ndl_pkg::DimBits'(1);
        row_err = row_err + sh_e - oh_e;
      end else begin
        row_err = row_err - oh_e;
      end
      if (src_row >= sh - ndl_pkg::DimBits'(1)) begin
        clear_position();
      end else begin
        src_row = src_row + ndl_pkg::DimBits'(1);
      end
    end else begin
      src_col = src_col + ndl_pkg::DimBits'(1);
    end
  endtask

  // Sample all channels at the clock edge; transfers happen on valid and ready
  always @(posedge clk_i or negedge rst_ni) begin
    luma_pick_t want;

    if (!rst_ni) begin
      src_w_q = ndl_pkg::SrcWidthRst;
      src_h_q = ndl_pkg::SrcHeightRst;
      out_w_q = ndl_pkg::OutWidthRst;
      out_h_q = ndl_pkg::OutHeightRst;
      clear_position();
      luma_due_q.delete();
      fail_count_o = 0;
      results_o    = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (ndl_pkg::cfg_idx_e'(cfg_i.index))
          ndl_pkg::CfgSrcWidth:  src_w_q = cfg_i.data;
          ndl_pkg::CfgSrcHeight: src_h_q = cfg_i.data;
          ndl_pkg::CfgOutWidth:  out_w_q = cfg_i.data;
          ndl_pkg::CfgOutHeight: out_h_q = cfg_i.data;
          default: ;
        endcase
      end

      if (gray_i.valid && gray_i.ready) begin
        results_o++;
        if (luma_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result gray=%0d row_end=%0b frame_end=%0b",
                                    gray_i.gray, gray_i.row_end, gray_i.frame_end));
        end else begin
          want = luma_due_q.pop_front();
          if (gray_i.gray !== want.gray) begin
            report_mismatch($sformatf("result %0d gray got %0d want %0d",
                                      results_o, gray_i.gray, want.gray));
          end
          if (gray_i.row_end !== want.row_end) begin
            report_mismatch($sformatf("result %0d row_end got %0b want %0b",
                                      results_o, gray_i.row_end, want.row_end));
          end
          if (gray_i.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("result %0d frame_end got %0b want %0b",
                                      results_o, gray_i.frame_end, want.frame_end));
          end
        end
      end

      if (pix_i.valid && pix_i.ready) begin
        step_downscaler(pix_i.red, pix_i.green, pix_i.blue, pix_i.frame_start);
      end

      pending_o <= luma_due_q.size();
    end
  end

endmodule

// ===== sim/nearest_downscale_to_luma_tb.sv =====
// ----------------------------------------------------------------------------
// nearest_downscale_to_luma_tb
// Drives source pixels and size settings into the downscaler, stalls the
// gray output at random, and reports the verdict of the attached checker.
// A short directed part hits color extremes, size clamping and automatic
// frame restart; the random part walks many frame sizes, mostly small and
// well-formed frames, some large or broken, under several idling phases.
// ----------------------------------------------------------------------------
module nearest_downscale_to_luma_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ClkHalfNs    = 5;
  localparam int unsigned ResetCycles  = 5;
  localparam int unsigned RandomPixels = 1600;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned QuietLimit   = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned pixels_sent    = 0;
  int unsigned reg_writes     = 0;
  int unsigned settings_used  = 0;
  int unsigned quiet_cycles   = 0;

  int unsigned fail_count;
  int unsigned luma_pending;
  int unsigned luma_results;

  ndl_cfg_if  cfg_if ();
  ndl_pix_if  pix_if ();
  ndl_gray_if gray_if ();

  always #(ClkHalfNs) clk_i = ~clk_i;

  nearest_downscale_to_luma DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .gray_o (gray_if)
  );

  nearest_downscale_to_luma_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .pix_i        (pix_if),
    .gray_i       (gray_if),
    .fail_count_o (fail_count),
    .pending_o    (luma_pending),
    .results_o    (luma_results)
  );

  // Stall the gray output at the current phase's rate
  always @(posedge clk_i) begin
    gray_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no channel has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (gray_if.valid && gray_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               QuietLimit, luma_pending);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned nonzero(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic [ndl_pkg::ChanBits-1:0] rand_chan();
    return ndl_pkg::ChanBits'($urandom_range(255));
  endfunction

  // Offer one pixel after a random idle gap and hold it until its transfer
  task automatic send_pixel(input logic [ndl_pkg::ChanBits-1:0] r,
                            input logic [ndl_pkg::ChanBits-1:0] g,
                            input logic [ndl_pkg::ChanBits-1:0] b, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.red         <= r;
    pix_if.green       <= g;
    pix_if.blue        <= b;
    pix_if.frame_start <= fs;
    do @(posedge clk_i); while (!pix_if.ready);
    pixels_sent++;
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline empty
  task automatic settle();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (luma_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all four size registers once the block is idle
  task automatic apply_sizes(input logic [ndl_pkg::DimBits-1:0] sw,
                             input logic [ndl_pkg::DimBits-1:0] sh,
                             input logic [ndl_pkg::DimBits-1:0] ow,
                             input logic [ndl_pkg::DimBits-1:0] oh);
    ndl_pkg::cfg_idx_e           order [4] = '{ndl_pkg::CfgSrcWidth, ndl_pkg::CfgSrcHeight,
                                               ndl_pkg::CfgOutWidth, ndl_pkg::CfgOutHeight};
    logic [ndl_pkg::DimBits-1:0] vals  [4];

    vals = '{sw, sh, ow, oh};
    settle();
    for (int k = 0; k < 4; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= order[k];
      cfg_if.data  <= vals[k];
      do @(posedge clk_i); while (!cfg_if.ready);
      reg_writes++;
    end
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // Send frames of random pixels; frame_start mostly on frame boundaries
  task automatic send_frames(input int unsigned frame_px, input int unsigned count,
                             input logic restart);
    int unsigned pos;
    logic        fs;

    pos = restart ? 0 : $urandom_range(frame_px - 1);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == 0 && restart) begin
        fs = 1'b1;
      end else if (pos == 0) begin
        fs = ($urandom_range(3) != 0);
      end else begin
        fs = ($urandom_range(49) == 0);
      end
      if (fs) begin
        pos = 0;
      end
      send_pixel(rand_chan(), rand_chan(), rand_chan(), fs);
      pos = (pos + 1) % frame_px;
    end
  endtask

  initial begin
    int unsigned sw;
    int unsigned sh;
    int unsigned ow;
    int unsigned oh;
    int unsigned count;
    int unsigned random_start;
    logic        large_frame;

    rst_ni             = 1'b0;
    pix_if.valid       = 1'b0;
    pix_if.red         = '0;
    pix_if.green       = '0;
    pix_if.blue        = '0;
    pix_if.frame_start = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = ndl_pkg::CfgSrcWidth;
    cfg_if.data        = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes: color extremes, then a restart in the middle of a row
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);

    // Upscale request on width, zero height; second frame restarts by itself
    apply_sizes(ndl_pkg::DimBits'(3), ndl_pkg::DimBits'(2), ndl_pkg::DimBits'(5),
                ndl_pkg::DimBits'(0));
    for (int i = 0; i < 10; i++) begin
      send_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
    end

    // Zero source width acts as one column
    apply_sizes(ndl_pkg::DimBits'(0), ndl_pkg::DimBits'(4), ndl_pkg::DimBits'(1),
                ndl_pkg::DimBits'(2));
    for (int i = 0; i < 6; i++) begin
      send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
    end

    // Largest sizes: a few pixels of a huge frame
    apply_sizes('1, '1, '1, '1);
    for (int i = 0; i < 3; i++) begin
      send_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
    end

    // Random sizes, mostly small frames; the phase cycles the idling pattern
    random_start = pixels_sent;
    while (pixels_sent - random_start < RandomPixels) begin
      large_frame = ($urandom_range(7) == 0);
      sw = $urandom_range(12);
      sh = $urandom_range(8);
      if (large_frame) begin
        if ($urandom_range(1) != 0) sw = $urandom_range(4095);
        if ($urandom_range(1) != 0) sh = $urandom_range(4095);
      end
      ow = $urandom_range(nonzero(sw) + 2);
      oh = $urandom_range(nonzero(sh) + 2);
      if (large_frame) begin
        if ($urandom_range(1) != 0) ow = $urandom_range(4095);
        if ($urandom_range(1) != 0) oh = $urandom_range(4095);
      end

      apply_sizes(ndl_pkg::DimBits'(sw), ndl_pkg::DimBits'(sh), ndl_pkg::DimBits'(ow),
                  ndl_pkg::DimBits'(oh));
      unique case (settings_used % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase

      if (large_frame) begin
        count = $urandom_range(80, 30);
      end else begin
        count = nonzero(sw) * nonzero(sh) * $urandom_range(3, 1) + $urandom_range(5);
      end
      // Stop at the pixel budget
      if (count > RandomPixels - (pixels_sent - random_start)) begin
        count = RandomPixels - (pixels_sent - random_start);
      end
      send_frames(nonzero(sw) * nonzero(sh), count, $urandom_range(1) != 0);
    end

    settle();
    $display("sent %0d source pixels under %0d size settings with %0d register writes",
             pixels_sent, settings_used, reg_writes);
    $display("checked %0d luma results, %0d mismatches", luma_results, fail_count);
    if (fail_count == 0 && luma_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
